// ===== hw/rtl/srrip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srrip_pkg;

   // fixed field widths of the channels
   localparam int SET_IN_W = 11;
   localparam int WAY_IN_W = 4;
   localparam int THR_W    = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HOT_THRESHOLD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLD_THRESHOLD = 1'd1;

   localparam logic REQ_VICTIM = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   localparam logic signed [THR_W-1:0] HOT_THRESHOLD_RESET  = 4'sd3;
   localparam logic signed [THR_W-1:0] COLD_THRESHOLD_RESET = 4'sd0;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_MOD   = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_LOAD  = 7'b0010000,
      ST_SCAN  = 7'b0100000,
      ST_WRITE = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srrip_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srrip_req_if;
   import srrip_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SET_IN_W-1:0] set_index;
   logic [WAY_IN_W-1:0] way_index;
   logic                is_hit;

   modport source (output valid, req_type, set_index, way_index, is_hit, input ready);
   modport sink   (input valid, req_type, set_index, way_index, is_hit, output ready);
endinterface

interface srrip_rsp_if;
   import srrip_pkg::*;
   logic                valid;
   logic                ready;
   logic [WAY_IN_W-1:0] victim_way;
   logic                victim_valid;

   modport source (output valid, victim_way, victim_valid, input ready);
   modport sink   (input valid, victim_way, victim_valid, output ready);
endinterface

interface srrip_csr_if;
   import srrip_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CSR_IDX_W-1:0]        index;
   logic signed [THR_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srrip_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srrip_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/set_adaptive_rrip_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  handshake      word
// req_chan   in   valid/ready    req_type, set_index, way_index, is_hit
// rsp_chan   out  valid/ready    victim_way, victim_valid
// csr_chan   in   valid/ready    index (0 hot, 1 cold threshold), data; always ready
//
// one request at a time: set reduction (reciprocal quotient, then remainder), then read,
// load, a way scan over NUM_WAYS ways for a victim request, then write.
// the write cycle raises response valid and returns to idle, so req_chan is ready again
// in the same cycle that the response turns valid.
// after reset a clearing pass writes NUM_SETS rows before req_chan is ready.
// a new request is taken while a response waits; the write cycle waits for a free response slot.

module set_adaptive_rrip_replacement #(
   parameter int NUM_SETS      = 2048,
   parameter int NUM_WAYS      = 16,
   parameter int RRPV_WIDTH    = 2,
   parameter int COUNTER_WIDTH = 4
) (
   input wire logic    clock,
   input wire logic    reset,
   srrip_req_if.sink   req_chan,
   srrip_rsp_if.source rsp_chan,
   srrip_csr_if.sink   csr_chan
);
   import srrip_pkg::*;

   localparam int SET_W   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W   = $clog2(NUM_WAYS);
   localparam int STEP_W  = $clog2(NUM_WAYS);
   localparam int ROW_W   = NUM_WAYS * RRPV_WIDTH;
   localparam int MEM_W   = ROW_W + COUNTER_WIDTH;
   localparam int CMP_W   = COUNTER_WIDTH > THR_W ? COUNTER_WIDTH : THR_W;
   localparam int QUO_SH  = SET_IN_W + $clog2(NUM_SETS);
   localparam int RCP_W   = SET_IN_W + 2;
   localparam int PROD_W  = SET_IN_W + RCP_W;

   localparam logic [RCP_W-1:0] SET_RCP =
      RCP_W'(((64'd1 << QUO_SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
   localparam logic [PROD_W-1:0] SET_CNT = PROD_W'(NUM_SETS);

   localparam logic [RRPV_WIDTH-1:0] RRPV_TOP = {RRPV_WIDTH{1'b1}};
   localparam logic [RRPV_WIDTH-1:0] RRPV_MID = {RRPV_WIDTH{1'b1}} - 1'b1;
   localparam logic signed [COUNTER_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNTER_WIDTH-1){1'b1}}};
   localparam logic signed [COUNTER_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNTER_WIDTH-1){1'b0}}};

   state_type state_ff, state_in;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SET_W-1:0]    clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [THR_W-1:0] hot_ff, hot_in, cold_ff, cold_in;

   // payload registers
   logic                req_type_ff;
   logic [WAY_IN_W-1:0] way_ff;
   logic                hit_ff;
   logic [SET_IN_W-1:0] rem_ff, rem_in;
   logic [SET_IN_W-1:0] quo_ff, quo_in;
   logic [ROW_W-1:0]    row_ff;
   logic signed [COUNTER_WIDTH-1:0] cnt_ff;
   logic [RRPV_WIDTH-1:0] top_ff, top_in;
   logic [WAY_W-1:0]    pick_ff, pick_in;
   logic [WAY_IN_W-1:0] victim_way_ff;
   logic                victim_valid_ff;

   logic              req_fire;
   logic              out_free;
   logic              mem_we;
   logic [SET_W-1:0]  mem_waddr;
   logic [MEM_W-1:0]  mem_wdata;
   logic [MEM_W-1:0]  mem_rdata;
   logic [SET_W-1:0]  set_addr;
   logic              last_mod;
   logic              last_way;
   logic [PROD_W-1:0] quo_prod;
   logic [WAY_W-1:0]  scan_way;
   logic [RRPV_WIDTH-1:0] scan_val;
   logic [ROW_W-1:0]  row_new;
   logic signed [COUNTER_WIDTH-1:0] cnt_new;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.victim_way   = victim_way_ff;
   assign rsp_chan.victim_valid = victim_valid_ff;

   assign set_addr = SET_W'(rem_ff);
   assign last_mod = (step_ff == STEP_W'(1));
   assign last_way = (step_ff == STEP_W'(NUM_WAYS - 1));
   assign quo_prod = PROD_W'(rem_ff) * PROD_W'(SET_RCP);
   assign scan_way = WAY_W'(step_ff);
   assign scan_val = row_ff[scan_way*RRPV_WIDTH +: RRPV_WIDTH];

   // new row and counter for the write cycle
   always_comb begin
      logic [RRPV_WIDTH-1:0] gap;
      logic                  in_range;
      logic signed [COUNTER_WIDTH-1:0] cnt_dec;
      logic signed [CMP_W-1:0] c_ext;
      logic [RRPV_WIDTH-1:0] ins_val;
      gap      = RRPV_TOP - top_ff;
      in_range = (32'(way_ff) < NUM_WAYS);
      cnt_dec  = (cnt_ff != CNT_MIN) ? cnt_ff - 1'b1 : cnt_ff;
      c_ext    = CMP_W'(cnt_dec);
      if (c_ext >= CMP_W'(hot_ff)) begin
         ins_val = '0;
      end else if (c_ext <= CMP_W'(cold_ff)) begin
         ins_val = RRPV_TOP;
      end else begin
         ins_val = RRPV_MID;
      end
      row_new = row_ff;
      cnt_new = cnt_ff;
      if (req_type_ff == REQ_VICTIM) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            row_new[w*RRPV_WIDTH +: RRPV_WIDTH] = row_ff[w*RRPV_WIDTH +: RRPV_WIDTH] + gap;
         end
      end else if (in_range) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(way_ff) == WAY_W'(w)) begin
               row_new[w*RRPV_WIDTH +: RRPV_WIDTH] = hit_ff ? '0 : ins_val;
            end
         end
         if (hit_ff) begin
            cnt_new = (cnt_ff != CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
         end else begin
            cnt_new = cnt_dec;
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = set_addr;
      mem_wdata = {cnt_new, row_new};
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = {{COUNTER_WIDTH{1'b0}}, {NUM_WAYS{RRPV_TOP}}};
      end else if (state_ff == ST_WRITE && out_free) begin
         mem_we = 1'b1;
      end
   end

   srrip_ram #(
      .WIDTH (MEM_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (set_addr),
      .rdata (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      top_in       = top_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      hot_in       = hot_ff;
      cold_in      = cold_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_HOT_THRESHOLD:  hot_in  = csr_chan.data;
            CSR_COLD_THRESHOLD: cold_in = csr_chan.data;
            default: ;
         endcase
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               rem_in   = req_chan.set_index;
               step_in  = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // set_index mod NUM_SETS: reciprocal quotient first, then the remainder
            if (!last_mod) begin
               quo_in  = SET_IN_W'(quo_prod >> QUO_SH);
               step_in = step_ff + 1'b1;
            end else begin
               rem_in   = rem_ff - SET_IN_W'(PROD_W'(quo_ff) * SET_CNT);
               step_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            top_in   = '0;
            pick_in  = '0;
            step_in  = '0;
            state_in = (req_type_ff == REQ_VICTIM) ? ST_SCAN : ST_WRITE;
         end
         ST_SCAN: begin
            // strict compare keeps the lowest way at the maximum
            if (scan_val > top_ff) begin
               top_in  = scan_val;
               pick_in = scan_way;
            end
            step_in = step_ff + 1'b1;
            if (last_way) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hot_ff       <= HOT_THRESHOLD_RESET;
         cold_ff      <= COLD_THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hot_ff       <= hot_in;
         cold_ff      <= cold_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      top_ff  <= top_in;
      pick_ff <= pick_in;
      if (req_fire) begin
         req_type_ff <= req_chan.req_type;
         way_ff      <= req_chan.way_index;
         hit_ff      <= req_chan.is_hit;
      end
      if (state_ff == ST_LOAD) begin
         row_ff <= mem_rdata[ROW_W-1:0];
         cnt_ff <= mem_rdata[MEM_W-1:ROW_W];
      end
      if (state_ff == ST_WRITE && out_free) begin
         victim_valid_ff <= (req_type_ff == REQ_VICTIM);
         victim_way_ff   <= (req_type_ff == REQ_VICTIM) ? WAY_IN_W'(pick_ff) : '0;
      end
   end

   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MOD) && (step_ff == '0))
      else $error("accepted word did not start the set reduction");

   a_set_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (32'(rem_ff) < NUM_SETS))
      else $error("set index not reduced below NUM_SETS");

   a_pick_behind_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(pick_ff) <= 32'(step_ff)))
      else $error("victim pick ahead of the scan position");

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WRITE))
      else $error("response raised outside the write cycle");

endmodule

`default_nettype wire
